@@ design/atr_pkg.sv @@
package atr_pkg;

  localparam int unsigned MAX_ATR_LEN = 64;
  localparam int unsigned CountW = 7;

  localparam logic [7:0] TS_DIRECT  = 8'h3B;
  localparam logic [7:0] TS_INVERSE = 8'h3F;

  typedef enum logic {
    OP_BYTE    = 1'b0,
    OP_RESTART = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    PH_TS   = 2'd0,
    PH_T0   = 2'd1,
    PH_BODY = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_BUSY     = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_BAD_TS   = 2'd2,
    ST_OVERRUN  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    KIND_TS   = 3'd0,
    KIND_T0   = 3'd1,
    KIND_TA   = 3'd2,
    KIND_TB   = 3'd3,
    KIND_TC   = 3'd4,
    KIND_TD   = 3'd5,
    KIND_HIST = 3'd6
  } kind_e;

  // expect_mask bit positions
  localparam int unsigned MaskTa = 0;
  localparam int unsigned MaskTb = 1;
  localparam int unsigned MaskTc = 2;

  typedef struct packed {
    phase_e              phase;
    logic [3:0]          expect_mask;
    logic [3:0]          hist_count;
    logic [3:0]          td_count;
    logic                tc_seen;
    logic [CountW-1:0]   byte_count;
    logic                convention;
    logic [7:0]          guard_value;
  } atr_state_t;

  typedef struct packed {
    status_e    status;
    kind_e      byte_kind;
    logic [3:0] group_index;
    logic       inverse_convention;
    logic [7:0] guard_time;
    logic [3:0] hist_left;
  } atr_result_t;

  localparam atr_state_t STATE_RESET = '{
    phase:       PH_TS,
    expect_mask: 4'd0,
    hist_count:  4'd0,
    td_count:    4'd0,
    tc_seen:     1'b0,
    byte_count:  '0,
    convention:  1'b0,
    guard_value: 8'd0
  };

endpackage

@@ design/atr_decode.sv @@
module atr_decode (
  input  atr_pkg::op_e         op_i,
  input  logic [7:0]           rx_byte_i,
  input  atr_pkg::atr_state_t  state_i,
  output atr_pkg::atr_state_t  state_o,
  output atr_pkg::atr_result_t result_o,
  output logic                 result_valid_o
);

  atr_pkg::atr_state_t  s;
  atr_pkg::atr_result_t r;

  always_comb begin
    s = state_i;
    r.status             = atr_pkg::ST_BUSY;
    r.byte_kind          = atr_pkg::KIND_TS;
    r.group_index        = 4'd0;
    r.inverse_convention = state_i.convention;
    r.guard_time         = state_i.guard_value;
    r.hist_left          = state_i.hist_count;
    result_valid_o       = 1'b1;

    if (op_i == atr_pkg::OP_RESTART) begin
      s              = atr_pkg::STATE_RESET;
      result_valid_o = 1'b0;
    end else if (state_i.phase == atr_pkg::PH_DONE ||
                 state_i.byte_count >= atr_pkg::CountW'(atr_pkg::MAX_ATR_LEN)) begin
      s.phase  = atr_pkg::PH_DONE;
      r.status = atr_pkg::ST_OVERRUN;
    end else begin
      s.byte_count = state_i.byte_count + 1'b1;
      if (state_i.phase == atr_pkg::PH_TS) begin
        if (rx_byte_i == atr_pkg::TS_DIRECT || rx_byte_i == atr_pkg::TS_INVERSE) begin
          s.convention         = (rx_byte_i == atr_pkg::TS_INVERSE);
          s.phase              = atr_pkg::PH_T0;
          r.inverse_convention = s.convention;
        end else begin
          s.phase              = atr_pkg::PH_DONE;
          r.status             = atr_pkg::ST_BAD_TS;
          r.inverse_convention = 1'b0;
          r.guard_time         = 8'd0;
          r.hist_left          = 4'd0;
        end
      end else begin
        if (state_i.phase == atr_pkg::PH_T0) begin
          s.hist_count  = rx_byte_i[3:0];
          s.expect_mask = rx_byte_i[7:4];
          s.phase       = atr_pkg::PH_BODY;
          r.byte_kind   = atr_pkg::KIND_T0;
        end else if (state_i.expect_mask != 4'd0) begin
          r.group_index = state_i.td_count;
          if (state_i.expect_mask[atr_pkg::MaskTa]) begin
            r.byte_kind   = atr_pkg::KIND_TA;
            s.expect_mask = state_i.expect_mask & 4'hE;
          end else if (state_i.expect_mask[atr_pkg::MaskTb]) begin
            r.byte_kind   = atr_pkg::KIND_TB;
            s.expect_mask = state_i.expect_mask & 4'hC;
          end else if (state_i.expect_mask[atr_pkg::MaskTc]) begin
            r.byte_kind   = atr_pkg::KIND_TC;
            s.expect_mask = state_i.expect_mask & 4'h8;
            // only the first TC sets the guard time
            if (!state_i.tc_seen) begin
              s.guard_value = rx_byte_i;
              s.tc_seen     = 1'b1;
            end
          end else begin
            r.byte_kind   = atr_pkg::KIND_TD;
            s.expect_mask = rx_byte_i[7:4];
            if (state_i.td_count != 4'hF) begin
              s.td_count = state_i.td_count + 1'b1;
            end
          end
        end else begin
          r.byte_kind = atr_pkg::KIND_HIST;
          if (state_i.hist_count != 4'd0) begin
            s.hist_count = state_i.hist_count - 1'b1;
          end
        end

        if (s.expect_mask == 4'd0 && s.hist_count == 4'd0) begin
          r.status = atr_pkg::ST_COMPLETE;
          s.phase  = atr_pkg::PH_DONE;
        end
        r.guard_time = s.guard_value;
        r.hist_left  = s.hist_count;
      end
    end
  end

  assign state_o  = s;
  assign result_o = r;

endmodule

@@ design/smartcard_atr_parser.sv @@
// A result appears on the output register in the cycle after its byte is taken.
// Throughput: one byte per cycle while in_stall_o is low; the parser state updates in the accepting cycle.
// A restart request is taken like a byte but produces no result.
// Input stalls only while the output register holds a result that is stalled.
// Reset (rst_ni low, asynchronous) returns the parser to waiting for TS and drops
// any pending result.
module smartcard_atr_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       op_i,
  input  logic [7:0] rx_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [2:0] byte_kind_o,
  output logic [3:0] group_index_o,
  output logic       inverse_convention_o,
  output logic [7:0] guard_time_o,
  output logic [3:0] hist_left_o
);

  atr_pkg::atr_state_t  state_q, state_d;
  atr_pkg::atr_result_t result_d, result_q;
  logic                 result_valid;
  logic                 out_valid_q;
  logic                 in_accept;

  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_accept  = in_valid_i & ~in_stall_o;

  atr_decode u_decode (
    .op_i           (atr_pkg::op_e'(op_i)),
    .rx_byte_i      (rx_byte_i),
    .state_i        (state_q),
    .state_o        (state_d),
    .result_o       (result_d),
    .result_valid_o (result_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atr_pkg::STATE_RESET;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        state_q <= state_d;
      end
      if (in_accept && result_valid) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && result_valid) begin
      result_q <= result_d;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = result_q.status;
  assign byte_kind_o          = result_q.byte_kind;
  assign group_index_o        = result_q.group_index;
  assign inverse_convention_o = result_q.inverse_convention;
  assign guard_time_o         = result_q.guard_time;
  assign hist_left_o          = result_q.hist_left;

  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && op_i == atr_pkg::OP_RESTART |=>
      state_q.phase == atr_pkg::PH_TS && state_q.byte_count == '0)
    else $error("restart did not return parser to TS");

  a_bad_ts_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == atr_pkg::ST_BAD_TS |->
      byte_kind_o == atr_pkg::KIND_TS && guard_time_o == 8'd0 &&
      hist_left_o == 4'd0 && !inverse_convention_o)
    else $error("bad TS result carries nonzero fields");

  a_overrun_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == atr_pkg::ST_OVERRUN |->
      byte_kind_o == atr_pkg::KIND_TS && group_index_o == 4'd0)
    else $error("overrun result carries kind or group");

  a_end_is_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept && result_valid && result_d.status != atr_pkg::ST_BUSY |=>
      state_q.phase == atr_pkg::PH_DONE)
    else $error("parser left finished phase unset after end or error");

  a_byte_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q.byte_count <= atr_pkg::CountW'(atr_pkg::MAX_ATR_LEN))
    else $error("byte count beyond maximum ATR length");

endmodule
